/* design/atlp_pkg.sv */
// Shared types, codes and prefix tables for the AT response line parser.
package atlp_pkg;

   // Item kinds on the request channel
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_CMD   = 2'd1;
   localparam logic [1:0] KIND_ABORT = 2'd2;

   // Event codes on the response channel
   localparam logic [1:0] EVENT_URC = 2'd0;
   localparam logic [1:0] EVENT_OK  = 2'd1;
   localparam logic [1:0] EVENT_ERR = 2'd2;

   // Characters with a special meaning
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_GT = 8'h3E;
   localparam logic [7:0] CHAR_SP = 8'h20;

   // Prefix table: OK, data prompt, ERROR, NO CARRIER, +CME ERROR:, +CMS ERROR:, RING
   localparam int PREFIX_NUM = 7;
   localparam logic [6:0] PREFIX_ALL  = 7'h7F;
   localparam logic [6:0] PREFIX_URC  = 7'h40;
   localparam logic [6:0] PREFIX_ERR  = 7'h3C;
   localparam logic [6:0] PREFIX_OK   = 7'h03;
   localparam logic [3:0] PREFIX_LEN [PREFIX_NUM] =
      '{4'd2, 4'd2, 4'd5, 4'd10, 4'd11, 4'd11, 4'd4};
   // Right-justified text, first character in the highest used byte
   localparam logic [87:0] PREFIX_STR [PREFIX_NUM] =
      '{"OK", "> ", "ERROR", "NO CARRIER", "+CME ERROR:", "+CMS ERROR:", "RING"};

   // Parse mode, one-hot
   typedef enum logic [2:0] {
      MODE_IDLE   = 3'b001,
      MODE_LINES  = 3'b010,
      MODE_PROMPT = 3'b100
   } mode_type;

   // Fill status of a small queue
   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;

   // One response word
   typedef struct packed {
      logic [1:0] event_res;
      logic [7:0] data_byte;
      logic       has_data;
      logic       last;
   } result_type;

   // True when a character at a line position breaks the given prefix
   function automatic logic prefix_miss(input int k, input logic [6:0] pos,
                                        input logic [7:0] ch);
      logic [7:0] want;
      logic       in_range;
      in_range = pos < 7'(PREFIX_LEN[k]);
      want     = 8'h00;
      if (in_range) begin
         want = PREFIX_STR[k][8*(int'(PREFIX_LEN[k]) - 1 - int'(pos)) +: 8];
      end
      return in_range && (want != ch);
   endfunction

endpackage

/* design/atlp_cmd_fifo.sv */
// Two-entry queue of emit commands between the line front end and the emitter.
module atlp_cmd_fifo #(
   parameter int WIDTH = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          pop_data,
   output atlp_pkg::fifo_status_type status
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;

   // Derive status and head
   assign status.empty = (cnt_ff == 2'd0);
   assign status.full  = (cnt_ff == 2'd2);
   assign pop_data     = entry_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Hold entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff != 2'd2 || pop))
      else $error("command pushed into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != 2'd0)
      else $error("command popped from an empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("command queue count out of range");

endmodule

/* design/atlp_front.sv */
// Front end: takes request words, builds lines, classifies them and issues emit commands.
module atlp_front #(
   parameter int BUFFER_DEPTH = 64,
   localparam int AW = $clog2(BUFFER_DEPTH),
   localparam int CMD_W = 2 + 2 * AW
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  logic [1:0]                req_kind,
   input  logic [7:0]                req_rx_byte,
   input  logic                      req_prompt_expected,
   output logic                      req_full,
   input  atlp_pkg::fifo_status_type cmd_status,
   input  logic                      back_busy,
   output logic                      cmd_push,
   output logic [CMD_W-1:0]          cmd_data,
   output logic                      wr_en,
   output logic [AW-1:0]             wr_addr,
   output logic [7:0]                wr_data
);

   localparam logic [AW-1:0] FILL_MAX = AW'(BUFFER_DEPTH - 1);

   // Held request word
   logic       held_valid_ff, held_valid_in;
   logic [1:0] held_kind_ff;
   logic [7:0] held_byte_ff;
   logic       held_prompt_ff;

   // Line state
   atlp_pkg::mode_type mode_ff, mode_in;
   logic [AW-1:0]      fill_ff, fill_in;
   logic [AW-1:0]      ls_ff, ls_in;
   logic [6:0]         alive_ff, alive_in;
   logic [7:0]         sh0_ff, sh0_in;
   logic [7:0]         sh1_ff, sh1_in;
   logic               sep_done_ff, sep_done_in;

   // Work signals
   logic          accept, consume, go, busy;
   logic          is_text, need_sep, trig, do_clear;
   logic [AW-1:0] f, l, len, t;
   logic [6:0]    al, hits, pos7;
   logic [7:0]    s0, s1;

   // Classify the held word
   assign is_text  = (held_kind_ff == atlp_pkg::KIND_BYTE) &&
                     (held_byte_ff != atlp_pkg::CHAR_CR) &&
                     (held_byte_ff != atlp_pkg::CHAR_LF);
   assign busy     = back_busy || !cmd_status.empty;
   assign go       = held_valid_ff && !cmd_status.full && !(is_text && busy);
   assign need_sep = is_text && !sep_done_ff && (fill_ff != '0) &&
                     (ls_ff == fill_ff) && (fill_ff != FILL_MAX);

   // Accept a new word when the holding slot frees up
   assign req_full      = held_valid_ff && !consume;
   assign accept        = req_push && !req_full;
   assign held_valid_in = accept ? 1'b1 : (consume ? 1'b0 : held_valid_ff);

   // Step the line state
   always_comb begin
      mode_in     = mode_ff;
      fill_in     = fill_ff;
      ls_in       = ls_ff;
      alive_in    = alive_ff;
      sh0_in      = sh0_ff;
      sh1_in      = sh1_ff;
      sep_done_in = sep_done_ff;
      wr_en       = 1'b0;
      wr_addr     = fill_ff;
      wr_data     = atlp_pkg::CHAR_LF;
      cmd_push    = 1'b0;
      cmd_data    = '0;
      consume     = 1'b0;
      do_clear    = 1'b0;
      f           = fill_ff;
      l           = ls_ff;
      al          = alive_ff;
      s0          = sh0_ff;
      s1          = sh1_ff;
      pos7        = '0;
      hits        = '0;
      len         = '0;
      t           = '0;
      trig        = 1'b0;
      if (go) begin
         if (need_sep) begin
            // Insert the newline between lines first
            wr_en       = 1'b1;
            fill_in     = fill_ff + AW'(1);
            ls_in       = fill_ff + AW'(1);
            sep_done_in = 1'b1;
            if (fill_ff == AW'(1)) begin
               sh1_in = atlp_pkg::CHAR_LF;
            end
         end else begin
            consume     = 1'b1;
            sep_done_in = 1'b0;
            case (held_kind_ff)
               atlp_pkg::KIND_CMD: begin
                  mode_in = held_prompt_ff ? atlp_pkg::MODE_PROMPT : atlp_pkg::MODE_LINES;
               end
               atlp_pkg::KIND_ABORT: begin
                  do_clear = 1'b1;
               end
               atlp_pkg::KIND_BYTE: begin
                  // Store a text byte and narrow the prefix set
                  if (is_text) begin
                     if (f == l) begin
                        al = atlp_pkg::PREFIX_ALL;
                     end
                     pos7 = 7'(f - l);
                     if (f != FILL_MAX) begin
                        wr_en   = 1'b1;
                        wr_addr = f;
                        wr_data = held_byte_ff;
                        if (f == AW'(0)) begin
                           s0 = held_byte_ff;
                        end
                        if (f == AW'(1)) begin
                           s1 = held_byte_ff;
                        end
                        for (int k = 0; k < atlp_pkg::PREFIX_NUM; k++) begin
                           if (atlp_pkg::prefix_miss(k, pos7, held_byte_ff)) begin
                              al[k] = 1'b0;
                           end
                        end
                        f = f + AW'(1);
                     end
                  end
                  // Close the line on newline or a complete data prompt
                  trig = (held_byte_ff == atlp_pkg::CHAR_LF) ||
                         (mode_ff == atlp_pkg::MODE_PROMPT && f == AW'(2) &&
                          s0 == atlp_pkg::CHAR_GT && s1 == atlp_pkg::CHAR_SP);
                  len = f - l;
                  for (int k = 0; k < atlp_pkg::PREFIX_NUM; k++) begin
                     hits[k] = al[k] && (7'(len) >= 7'(atlp_pkg::PREFIX_LEN[k]));
                  end
                  t = (l != '0) ? l - AW'(1) : '0;
                  if (trig && f != l) begin
                     if ((hits & atlp_pkg::PREFIX_URC) != '0 ||
                         mode_ff == atlp_pkg::MODE_IDLE) begin
                        // Emit this line alone, then drop it
                        cmd_push = 1'b1;
                        cmd_data = {atlp_pkg::EVENT_URC, l, f};
                        l        = t;
                        f        = t;
                     end else if ((hits & atlp_pkg::PREFIX_ERR) != '0) begin
                        cmd_push = 1'b1;
                        cmd_data = {atlp_pkg::EVENT_ERR, AW'(0), f};
                        do_clear = 1'b1;
                     end else if ((hits & atlp_pkg::PREFIX_OK) != '0) begin
                        // Emit the reply without the final line
                        cmd_push = 1'b1;
                        cmd_data = {atlp_pkg::EVENT_OK, AW'(0), t};
                        do_clear = 1'b1;
                     end else begin
                        l = f;
                     end
                  end
                  fill_in  = f;
                  ls_in    = l;
                  alive_in = al;
                  sh0_in   = s0;
                  sh1_in   = s1;
               end
               default: begin
               end
            endcase
            if (do_clear) begin
               mode_in  = atlp_pkg::MODE_IDLE;
               fill_in  = '0;
               ls_in    = '0;
               alive_in = atlp_pkg::PREFIX_ALL;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         mode_ff       <= atlp_pkg::MODE_IDLE;
         fill_ff       <= '0;
         ls_ff         <= '0;
         alive_ff      <= atlp_pkg::PREFIX_ALL;
         sep_done_ff   <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         mode_ff       <= mode_in;
         fill_ff       <= fill_in;
         ls_ff         <= ls_in;
         alive_ff      <= alive_in;
         sep_done_ff   <= sep_done_in;
      end
   end

   // Hold payload and first two stored bytes
   always_ff @(posedge clock) begin
      if (accept) begin
         held_kind_ff   <= req_kind;
         held_byte_ff   <= req_rx_byte;
         held_prompt_ff <= req_prompt_expected;
      end
      sh0_ff <= sh0_in;
      sh1_ff <= sh1_in;
   end

   a_no_write_while_emit: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !busy)
      else $error("line memory written while a reply is still read out");
   a_start_in_fill: assert property (@(posedge clock) disable iff (reset)
      ls_ff <= fill_ff)
      else $error("line start beyond fill count");
   a_sep_has_word: assert property (@(posedge clock) disable iff (reset)
      sep_done_ff |-> held_valid_ff)
      else $error("separator phase without a held word");

endmodule

/* design/atlp_back.sv */
// Back end: line memory and emitter that streams commanded ranges out as response words.
module atlp_back #(
   parameter int BUFFER_DEPTH = 64,
   localparam int AW = $clog2(BUFFER_DEPTH),
   localparam int CMD_W = 2 + 2 * AW
) (
   input  logic                      clock,
   input  logic                      reset,
   input  atlp_pkg::fifo_status_type cmd_status,
   input  logic [CMD_W-1:0]          cmd_data,
   output logic                      cmd_pop,
   output logic                      busy,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [7:0]                wr_data,
   input  logic                      rsp_pop,
   output logic                      rsp_empty,
   output atlp_pkg::result_type      rsp_word
);

   // Line memory
   logic [7:0] store_ff [BUFFER_DEPTH];
   logic [7:0] mem_q_ff;

   // Emitter
   logic          active_ff, active_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] end_ff, end_in;
   logic [1:0]    res_ff, res_in;
   logic          empty_ff, empty_in;
   logic          issue, issue_ok, issue_last;

   // Read stage
   logic       rd_valid_ff;
   logic [1:0] rd_res_ff;
   logic       rd_last_ff;
   logic       rd_has_ff;

   // Output queue
   atlp_pkg::result_type oq_ff [2];
   atlp_pkg::result_type oq_word;
   logic                 oq_wr_ff, oq_rd_ff;
   logic [1:0]           oq_cnt_ff, oq_cnt_in;
   logic                 oq_pop;
   logic [2:0]           occ;

   assign busy      = active_ff;
   assign cmd_pop   = !active_ff && !cmd_status.empty;
   assign rsp_empty = (oq_cnt_ff == 2'd0);
   assign rsp_word  = oq_ff[oq_rd_ff];
   assign oq_pop    = rsp_pop && !rsp_empty;

   // Issue a read only when its word is sure to find room
   assign occ        = {1'b0, oq_cnt_ff} + {2'b0, rd_valid_ff} - {2'b0, oq_pop};
   assign issue_ok   = occ < 3'd2;
   assign issue      = active_ff && issue_ok;
   assign issue_last = empty_ff || (ptr_ff + AW'(1) == end_ff);

   // Load a command, then advance through its range
   always_comb begin
      active_in = active_ff;
      ptr_in    = ptr_ff;
      end_in    = end_ff;
      res_in    = res_ff;
      empty_in  = empty_ff;
      if (cmd_pop) begin
         active_in = 1'b1;
         res_in    = cmd_data[CMD_W-1 -: 2];
         ptr_in    = cmd_data[2*AW-1 -: AW];
         end_in    = cmd_data[AW-1:0];
         empty_in  = (cmd_data[2*AW-1 -: AW] == cmd_data[AW-1:0]);
      end else if (issue) begin
         ptr_in = ptr_ff + AW'(1);
         if (issue_last) begin
            active_in = 1'b0;
         end
      end
   end

   // Build the word that enters the output queue
   always_comb begin
      oq_word.event_res = rd_res_ff;
      oq_word.data_byte = rd_has_ff ? mem_q_ff : 8'h00;
      oq_word.has_data  = rd_has_ff;
      oq_word.last      = rd_last_ff;
      oq_cnt_in         = oq_cnt_ff + {1'b0, rd_valid_ff} - {1'b0, oq_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         rd_valid_ff <= 1'b0;
         oq_wr_ff    <= 1'b0;
         oq_rd_ff    <= 1'b0;
         oq_cnt_ff   <= 2'd0;
      end else begin
         active_ff   <= active_in;
         rd_valid_ff <= issue;
         oq_wr_ff    <= oq_wr_ff ^ rd_valid_ff;
         oq_rd_ff    <= oq_rd_ff ^ oq_pop;
         oq_cnt_ff   <= oq_cnt_in;
      end
   end

   // Hold emitter payload and read-stage tags
   always_ff @(posedge clock) begin
      ptr_ff   <= ptr_in;
      end_ff   <= end_in;
      res_ff   <= res_in;
      empty_ff <= empty_in;
      if (issue) begin
         rd_res_ff  <= res_ff;
         rd_last_ff <= issue_last;
         rd_has_ff  <= !empty_ff;
      end
      if (rd_valid_ff) begin
         oq_ff[oq_wr_ff] <= oq_word;
      end
   end

   // Write and read the line memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (issue) begin
         mem_q_ff <= store_ff[ptr_ff];
      end
   end

   a_oq_room: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (oq_cnt_ff != 2'd2 || oq_pop))
      else $error("read word arrives at a full output queue");
   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      (issue && !empty_ff) |-> ptr_ff < end_ff)
      else $error("emitter reads past the commanded range");
   a_oq_count: assert property (@(posedge clock) disable iff (reset)
      oq_cnt_ff != 2'd3)
      else $error("output queue count out of range");

endmodule

/* design/at_response_line_parser_unit.sv */
// Top level of the AT response line parser: front end, command queue and emitter.
//
// Request channel (req_push / req_full): one word per modem byte (kind 0), per
// command sent (kind 1, with req_prompt_expected) or per abort (kind 2).
// Response channel (rsp_empty / rsp_pop): one word per emitted byte, tagged with
// the event type; rsp_last marks the end of a line or reply, and an empty final
// reply gives one word with rsp_has_data low.
// The front end holds each request word and, when a newline must be placed
// between stored lines, writes that newline first. A finished line or reply is
// queued as a range command and streamed from the line memory at one byte per
// cycle while the output queue has room, passing the emitter's read stage first.
// A text byte waits in the front end while an earlier range is still being read
// out, since it would overwrite the line memory; other words keep flowing. A
// range command needs newly stored text, so at most one is pending at a time.
// When the receiver stalls, the two-word output queue fills, the emitter halts
// and the front end stalls once a text byte comes up.
// Reset clears all control state; the line memory is not cleared.
module at_response_line_parser_unit #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_rx_byte,
   input  logic       req_prompt_expected,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_event_res,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_has_data,
   output logic       rsp_last
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int CMD_W = 2 + 2 * AW;

   atlp_pkg::fifo_status_type cmd_status;
   atlp_pkg::result_type      rsp_word;
   logic                      cmd_push, cmd_pop, back_busy;
   logic [CMD_W-1:0]          cmd_in, cmd_out;
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [7:0]                wr_data;

   // Build and classify lines
   atlp_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_kind            (req_kind),
      .req_rx_byte         (req_rx_byte),
      .req_prompt_expected (req_prompt_expected),
      .req_full            (req_full),
      .cmd_status          (cmd_status),
      .back_busy           (back_busy),
      .cmd_push            (cmd_push),
      .cmd_data            (cmd_in),
      .wr_en               (wr_en),
      .wr_addr             (wr_addr),
      .wr_data             (wr_data)
   );

   // Queue emit commands
   atlp_cmd_fifo #(.WIDTH(CMD_W)) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .status    (cmd_status)
   );

   // Stream ranges out of the line memory
   atlp_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_status (cmd_status),
      .cmd_data   (cmd_out),
      .cmd_pop    (cmd_pop),
      .busy       (back_busy),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_word   (rsp_word)
   );

   assign rsp_event_res = rsp_word.event_res;
   assign rsp_data_byte = rsp_word.data_byte;
   assign rsp_has_data  = rsp_word.has_data;
   assign rsp_last      = rsp_word.last;

endmodule

/* tb/atlp_reply_checker.sv */
// Reply predictor and word checker for the AT response line parser.
module atlp_reply_checker #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_rx_byte,
   input  logic       req_prompt_expected,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic [1:0] rsp_event_res,
   input  logic [7:0] rsp_data_byte,
   input  logic       rsp_has_data,
   input  logic       rsp_last,
   output int         mismatches,
   output int         replies_owed
);

   // Shadow parser state
   atlp_pkg::mode_type parse_mode;
   logic [7:0]         line_mem [BUFFER_DEPTH];
   int unsigned        fill;
   int unsigned        start;
   logic [6:0]         alive;

   // Response words still owed by the block, oldest first
   atlp_pkg::result_type reply_q [$];
   int                   fail_count = 0;
   int                   owed_count = 0;

   assign mismatches   = fail_count;
   assign replies_owed = owed_count;

   // Prefix text, indexed in the same order as the package masks
   function automatic string prefix_text(input int k);
      case (k)
         0:       return "OK";
         1:       return "> ";
         2:       return "ERROR";
         3:       return "NO CARRIER";
         4:       return "+CME ERROR:";
         5:       return "+CMS ERROR:";
         default: return "RING";
      endcase
   endfunction

   task automatic clear_state();
      parse_mode = atlp_pkg::MODE_IDLE;
      for (int i = 0; i < BUFFER_DEPTH; i++) line_mem[i] = 8'h00;
      fill  = 0;
      start = 0;
      alive = atlp_pkg::PREFIX_ALL;
   endtask

   // Store one byte unless the buffer is full; one slot stays unused
   function automatic bit store_byte(input logic [7:0] ch);
      if (fill < BUFFER_DEPTH - 1) begin
         line_mem[fill] = ch;
         fill++;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Store a text byte and drop every prefix it breaks
   task automatic add_text_byte(input logic [7:0] ch);
      int unsigned pos;
      string       p;
      if (fill == start) alive = atlp_pkg::PREFIX_ALL;
      pos = fill - start;
      if (!store_byte(ch)) return;
      for (int k = 0; k < atlp_pkg::PREFIX_NUM; k++) begin
         p = prefix_text(k);
         if (pos < p.len() && p[pos] != ch) alive[k] = 1'b0;
      end
   endtask

   task automatic add_reply(input logic [1:0] ev, input logic [7:0] b, input logic has,
                            input logic fin);
      atlp_pkg::result_type w;
      w.event_res = ev;
      w.data_byte = b;
      w.has_data  = has;
      w.last      = fin;
      reply_q.push_back(w);
   endtask

   task automatic emit_span(input logic [1:0] ev, input int unsigned from,
                            input int unsigned upto);
      for (int unsigned i = from; i < upto && i < BUFFER_DEPTH; i++)
         add_reply(ev, line_mem[i], 1'b1, i == upto - 1);
   endtask

   // Classify the finished line and emit what it releases
   task automatic close_line();
      int unsigned len;
      logic [6:0]  hits;
      logic [1:0]  ev;
      string       p;
      if (fill == start) return;
      len  = fill - start;
      hits = '0;
      for (int k = 0; k < atlp_pkg::PREFIX_NUM; k++) begin
         p = prefix_text(k);
         if (alive[k] && len >= p.len()) hits[k] = 1'b1;
      end

      // unsolicited, or nobody waiting: emit the line alone and drop it
      if ((hits & atlp_pkg::PREFIX_URC) != '0 || parse_mode == atlp_pkg::MODE_IDLE) begin
         emit_span(atlp_pkg::EVENT_URC, start, fill);
         if (start > 0) start--;
         fill = start;
         return;
      end

      if ((hits & atlp_pkg::PREFIX_ERR) != '0) begin
         start = fill;
         ev    = atlp_pkg::EVENT_ERR;
      end else if ((hits & atlp_pkg::PREFIX_OK) != '0) begin
         // drop the OK line together with its separator
         if (start > 0) start--;
         fill = start;
         ev   = atlp_pkg::EVENT_OK;
      end else begin
         // intermediate line: keep it
         start = fill;
         return;
      end

      if (fill == 0) add_reply(ev, 8'h00, 1'b0, 1'b1);
      else emit_span(ev, 0, fill);
      clear_state();
   endtask

   task automatic parse_word(input logic [1:0] kind, input logic [7:0] ch,
                             input logic prompt);
      case (kind)
         atlp_pkg::KIND_CMD: begin
            parse_mode = prompt ? atlp_pkg::MODE_PROMPT : atlp_pkg::MODE_LINES;
         end
         atlp_pkg::KIND_ABORT: begin
            clear_state();
         end
         atlp_pkg::KIND_BYTE: begin
            if (ch != atlp_pkg::CHAR_CR && ch != atlp_pkg::CHAR_LF) begin
               // separate from the previous stored line
               if (fill > 0 && start == fill) begin
                  void'(store_byte(atlp_pkg::CHAR_LF));
                  start = fill;
               end
               add_text_byte(ch);
            end
            if (ch == atlp_pkg::CHAR_LF ||
                (parse_mode == atlp_pkg::MODE_PROMPT && fill == 2 &&
                 line_mem[0] == atlp_pkg::CHAR_GT && line_mem[1] == atlp_pkg::CHAR_SP))
               close_line();
         end
         default: ;
      endcase
   endtask

   // Compare one popped word with the oldest expectation
   task automatic check_word();
      atlp_pkg::result_type want;
      if (reply_q.size() == 0) begin
         $error("response word with none expected: event_res %0d data_byte 0x%02h",
                rsp_event_res, rsp_data_byte);
         fail_count++;
      end else begin
         want = reply_q.pop_front();
         if (rsp_event_res !== want.event_res) begin
            $error("rsp_event_res: expected %0d, got %0d", want.event_res, rsp_event_res);
            fail_count++;
         end
         if (rsp_data_byte !== want.data_byte) begin
            $error("rsp_data_byte: expected 0x%02h, got 0x%02h", want.data_byte,
                   rsp_data_byte);
            fail_count++;
         end
         if (rsp_has_data !== want.has_data) begin
            $error("rsp_has_data: expected %0b, got %0b", want.has_data, rsp_has_data);
            fail_count++;
         end
         if (rsp_last !== want.last) begin
            $error("rsp_last: expected %0b, got %0b", want.last, rsp_last);
            fail_count++;
         end
      end
   endtask

   // Watch both channels at each edge
   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         reply_q.delete();
      end else begin
         if (rsp_pop && !rsp_empty) check_word();
         if (req_push && !req_full) parse_word(req_kind, req_rx_byte, req_prompt_expected);
      end
      owed_count = reply_q.size();
   end

endmodule

/* tb/at_response_line_parser_unit_test.sv */
// Stimulus, watchdog and verdict for the AT response line parser.
module at_response_line_parser_unit_test;

   localparam int         BUFFER_DEPTH   = 64;
   localparam logic [1:0] KIND_UNUSED    = 2'd3;
   localparam int         ITEMS          = 180;
   localparam int         CALM_ITEMS     = 30;
   localparam int         LONG_HOLD      = 300;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         DRAIN_CYCLES   = 32;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic [1:0] req_kind;
   logic [7:0] req_rx_byte;
   logic       req_prompt_expected;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [1:0] rsp_event_res;
   logic [7:0] rsp_data_byte;
   logic       rsp_has_data;
   logic       rsp_last;
   int         mismatches;
   int         replies_owed;

   // Stimulus control for the sender, the receiver and the watchdog
   bit calm         = 1'b0;
   bit send_lazy    = 1'b0;
   bit hold_request = 1'b0;
   int words_sent   = 0;
   int quiet_cycles = 0;

   always #10 clock = ~clock;

   at_response_line_parser_unit #(.BUFFER_DEPTH(BUFFER_DEPTH)) DUT (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_kind            (req_kind),
      .req_rx_byte         (req_rx_byte),
      .req_prompt_expected (req_prompt_expected),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_event_res       (rsp_event_res),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_has_data        (rsp_has_data),
      .rsp_last            (rsp_last)
   );

   atlp_reply_checker #(.BUFFER_DEPTH(BUFFER_DEPTH)) reply_check (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_kind            (req_kind),
      .req_rx_byte         (req_rx_byte),
      .req_prompt_expected (req_prompt_expected),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_event_res       (rsp_event_res),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_has_data        (rsp_has_data),
      .rsp_last            (rsp_last),
      .mismatches          (mismatches),
      .replies_owed        (replies_owed)
   );

   // Offer one word and hold it until accepted, then maybe idle a while
   task automatic send_word(input logic [1:0] kind, input logic [7:0] ch,
                            input logic prompt);
      req_push            <= 1'b1;
      req_kind            <= kind;
      req_rx_byte         <= ch;
      req_prompt_expected <= prompt;
      do @(posedge clock); while (req_full);
      if (kind != KIND_UNUSED) words_sent++;
      if (!calm && send_lazy && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Line content: mostly capitals and spaces, some arbitrary bytes, never LF
   function automatic logic [7:0] text_char();
      logic [7:0] c;
      case ($urandom_range(0, 5))
         0: begin
            c = 8'($urandom_range(0, 255));
            if (c == atlp_pkg::CHAR_LF) c = atlp_pkg::CHAR_SP;
         end
         1:       c = atlp_pkg::CHAR_SP;
         default: c = 8'($urandom_range("A", "Z"));
      endcase
      return c;
   endfunction

   function automatic string near_miss(input int k);
      case (k)
         0:       return "O";
         1:       return "RIN";
         2:       return "ERRO";
         3:       return "NO CARRIE";
         4:       return "+CME ERR";
         default: return ">";
      endcase
   endfunction

   function automatic string final_text(input int k);
      case (k)
         0:       return "OK";
         1:       return "ERROR";
         2:       return "NO CARRIER";
         3:       return "+CME ERROR:";
         4:       return "+CMS ERROR:";
         default: return "> ";
      endcase
   endfunction

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(atlp_pkg::KIND_BYTE, s[i], 1'($urandom));
   endtask

   task automatic send_noise_text(input int n);
      for (int i = 0; i < n; i++) send_word(atlp_pkg::KIND_BYTE, text_char(), 1'($urandom));
   endtask

   // Close a line with one of the usual terminators
   task automatic end_line();
      case ($urandom_range(0, 3))
         1: begin
            send_word(atlp_pkg::KIND_BYTE, atlp_pkg::CHAR_CR, 1'($urandom));
            send_word(atlp_pkg::KIND_BYTE, atlp_pkg::CHAR_LF, 1'($urandom));
         end
         2: begin
            send_word(atlp_pkg::KIND_BYTE, atlp_pkg::CHAR_CR, 1'($urandom));
            send_word(atlp_pkg::KIND_BYTE, atlp_pkg::CHAR_CR, 1'($urandom));
            send_word(atlp_pkg::KIND_BYTE, atlp_pkg::CHAR_LF, 1'($urandom));
         end
         default: send_word(atlp_pkg::KIND_BYTE, atlp_pkg::CHAR_LF, 1'($urandom));
      endcase
   endtask

   task automatic send_abort();
      send_word(atlp_pkg::KIND_ABORT, 8'($urandom), 1'($urandom));
   endtask

   // Command, optional intermediate and unsolicited lines, final reply
   task automatic run_exchange(input bit prompt);
      int lines;
      send_word(atlp_pkg::KIND_CMD, 8'($urandom), prompt);
      lines = prompt ? $urandom_range(0, 1) : $urandom_range(0, 3);
      for (int i = 0; i < lines; i++) begin
         case (prompt ? 0 : $urandom_range(0, 5))
            0: send_text("RING");
            1: send_text(near_miss($urandom_range(0, 5)));
            default: send_noise_text($urandom_range(1, 8));
         endcase
         if (!prompt && $urandom_range(0, 2) == 0) send_noise_text($urandom_range(1, 3));
         end_line();
      end
      if (prompt && $urandom_range(0, 1) == 1) begin
         send_text("> ");
      end else begin
         send_text(final_text($urandom_range(0, 5)));
         if ($urandom_range(0, 1) == 1) send_noise_text($urandom_range(1, 4));
         end_line();
      end
   endtask

   // Second command arrives while the first reply is still being gathered
   task automatic run_busy_command();
      send_word(atlp_pkg::KIND_CMD, 8'($urandom), 1'b0);
      send_noise_text($urandom_range(1, 6));
      end_line();
      send_word(atlp_pkg::KIND_CMD, 8'($urandom), 1'b1);
      send_noise_text($urandom_range(3, 6));
      end_line();
      send_text(final_text($urandom_range(0, 4)));
      end_line();
   endtask

   task automatic run_noise();
      repeat ($urandom_range(3, 10))
         send_word(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
      if ($urandom_range(0, 1) == 1) send_abort();
   endtask

   // Start a reply and abandon it halfway
   task automatic run_broken();
      send_word(atlp_pkg::KIND_CMD, 8'($urandom), 1'($urandom));
      if ($urandom_range(0, 1) == 1) begin
         send_noise_text($urandom_range(1, 5));
         end_line();
      end
      send_text(near_miss($urandom_range(0, 5)));
      send_abort();
   endtask

   // Error reply that overflows the store and is truncated
   task automatic run_full_error();
      send_abort();
      send_word(atlp_pkg::KIND_CMD, 8'($urandom), 1'b0);
      send_text("ERROR");
      send_noise_text(BUFFER_DEPTH - 4);
      end_line();
   endtask

   // Fill the store so the next separator takes its last slot and later bytes are dropped
   task automatic run_full_stuck();
      send_abort();
      send_word(atlp_pkg::KIND_CMD, 8'($urandom), 1'b0);
      send_noise_text(BUFFER_DEPTH - 2);
      end_line();
      send_text("OK");
      end_line();
      send_abort();
   endtask

   // Receiver holds off while idle lines keep coming
   task automatic run_backpressure();
      send_abort();
      hold_request = 1'b1;
      repeat (5) begin
         send_noise_text($urandom_range(4, 10));
         end_line();
      end
   endtask

   // Sender: directed words, then random sequences, then drain
   initial begin
      bit stuck_done;
      bit error_done;
      bit pressure_done;
      stuck_done    = 1'b0;
      error_done    = 1'b0;
      pressure_done = 1'b0;
      reset               <= 1'b1;
      req_push            <= 1'b0;
      req_kind            <= atlp_pkg::KIND_BYTE;
      req_rx_byte         <= 8'h00;
      req_prompt_expected <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // unknown kind, then an idle line with extreme bytes
      send_word(KIND_UNUSED, 8'hFF, 1'b1);
      send_word(atlp_pkg::KIND_BYTE, 8'h00, 1'b0);
      send_word(atlp_pkg::KIND_BYTE, 8'hFF, 1'b1);
      end_line();
      // data prompt completes with no data
      send_word(atlp_pkg::KIND_CMD, 8'h00, 1'b1);
      send_text("> ");
      // short line stays intermediate, then OK releases it
      send_word(atlp_pkg::KIND_CMD, 8'hFF, 1'b0);
      send_text("RI");
      end_line();
      send_text("OK");
      end_line();
      // empty final reply
      send_word(atlp_pkg::KIND_CMD, 8'h5A, 1'b0);
      send_text("OK");
      end_line();
      send_abort();

      while (words_sent < ITEMS) begin
         calm      = (words_sent >= ITEMS - CALM_ITEMS);
         send_lazy = 1'($urandom);
         if (!error_done && words_sent >= 40) begin
            run_full_error();
            error_done = 1'b1;
         end else if (!pressure_done && words_sent >= 100) begin
            run_backpressure();
            pressure_done = 1'b1;
         end else if (!stuck_done && words_sent >= 120) begin
            run_full_stuck();
            stuck_done = 1'b1;
         end else begin
            case ($urandom_range(0, 9))
               5: begin
                  send_noise_text($urandom_range(1, 8));
                  end_line();
               end
               6: run_noise();
               7: run_broken();
               8: run_busy_command();
               9: run_exchange(1'b1);
               default: run_exchange(1'b0);
            endcase
         end
      end
      req_push <= 1'b0;

      // wait for the owed replies, then let the block settle
      while (replies_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && replies_owed == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Receiver: random pop bursts in windows, one long hold on request
   initial begin
      int  window;
      bit  lazy;
      window = 0;
      lazy   = 1'b0;
      forever begin
         if (window == 0) begin
            lazy   = 1'($urandom);
            window = 64;
         end
         window--;
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_pop <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm && lazy && $urandom_range(0, 5) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
      end
   end

   // Watchdog: end the run when no word moves for too long
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
